[design/hsvrgb_pkg.sv]
`default_nettype none

package hsvrgb_pkg;

	localparam int HUE_W  = 15;
	localparam int SAT_W  = 13;
	localparam int CH_W   = 8;
	localparam int AMT_HW = 16;
	localparam int AMT_QW = 14;

	localparam int HUE_FULL = 23040;
	localparam int HUE_SEG  = 3840;
	localparam int Q_ONE    = 4096;

	localparam logic [23:0] K_SCALE = 24'd15728640;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_SET = 1'b1;

	localparam logic [2:0] SEL_NONE = 3'b000;
	localparam logic [2:0] SEL_HUE  = 3'b001;
	localparam logic [2:0] SEL_SAT  = 3'b010;
	localparam logic [2:0] SEL_VAL  = 3'b100;
	localparam logic [2:0] SEL_ALL  = 3'b111;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WRAP   = 3'd1;
	localparam logic [2:0] ST_DIVSEG = 3'd2;
	localparam logic [2:0] ST_MULA   = 3'd3;
	localparam logic [2:0] ST_MULB   = 3'd4;
	localparam logic [2:0] ST_STORE  = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	localparam logic [1:0] CH_V = 2'd0;
	localparam logic [1:0] CH_Q = 2'd1;
	localparam logic [1:0] CH_T = 2'd2;
	localparam logic [1:0] CH_P = 2'd3;

endpackage

`default_nettype wire

[design/hsv_color_state_to_rgb_unit.sv]
`default_nettype none

// Lamp color held as hue (1/64 degree, wraps at 360 degrees), saturation and
// value (Q1.12, clamped to 0..1). Each input transfer adds to or sets the
// components chosen by apply_mask, then one transfer of 8-bit red, green and
// blue follows from the six-segment HSV conversion. Each item goes through
// hue wrap, then a segment search by repeated subtraction of 60 degrees,
// then the four color terms, which share one 17x24 multiplier (two
// products per term). in_stall stays high from the input transfer until
// the result is loaded into an output register, where it sits until it is
// taken.
module hsv_color_state_to_rgb_unit (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic                                    command,
	input  wire logic [2:0]                              apply_mask,
	input  wire logic signed [hsvrgb_pkg::AMT_HW-1:0]    hue_amount,
	input  wire logic signed [hsvrgb_pkg::AMT_QW-1:0]    sat_amount,
	input  wire logic signed [hsvrgb_pkg::AMT_QW-1:0]    val_amount,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic [hsvrgb_pkg::CH_W-1:0]                  red,
	output logic [hsvrgb_pkg::CH_W-1:0]                  green,
	output logic [hsvrgb_pkg::CH_W-1:0]                  blue
);
	import hsvrgb_pkg::*;

	function automatic logic [SAT_W-1:0] clamp_unit(input logic signed [14:0] x);
		logic [SAT_W-1:0] r;
		if (x < 15'sd0) begin
			r = '0;
		end else if (x > 15'sd4096) begin
			r = SAT_W'(Q_ONE);
		end else begin
			r = x[SAT_W-1:0];
		end
		return r;
	endfunction

	logic [2:0]               state_q;
	logic [HUE_W-1:0]         hue_now_q;
	logic [SAT_W-1:0]         sat_now_q;
	logic [SAT_W-1:0]         val_now_q;
	logic signed [16:0]       hw_q;
	logic [HUE_W-1:0]         f_q;
	logic [2:0]               seg_q;
	logic [1:0]               idx_q;
	logic [40:0]              prod_q;
	logic [CH_W-1:0]          ch_q [4];
	logic                     out_valid_q;
	logic [CH_W-1:0]          red_q, green_q, blue_q;

	logic                     in_xfer, out_xfer, load_out;
	logic signed [14:0]       sat_next_raw, val_next_raw;
	logic signed [16:0]       hue_next_raw;
	logic [11:0]              x_sel, f12;
	logic [16:0]              mul_a;
	logic [23:0]              mul_b;
	logic [40:0]              mul_p;
	logic [CH_W-1:0]          r_sel, g_sel, b_sel;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

	always_comb begin
		if (command == CMD_SET) begin
			sat_next_raw = {sat_amount[AMT_QW-1], sat_amount};
			val_next_raw = {val_amount[AMT_QW-1], val_amount};
			hue_next_raw = {hue_amount[AMT_HW-1], hue_amount};
		end else begin
			sat_next_raw = $signed({2'b00, sat_now_q}) + $signed({sat_amount[AMT_QW-1], sat_amount});
			val_next_raw = $signed({2'b00, val_now_q}) + $signed({val_amount[AMT_QW-1], val_amount});
			hue_next_raw = $signed({2'b00, hue_now_q}) + $signed({hue_amount[AMT_HW-1], hue_amount});
		end
	end

	assign f12 = f_q[11:0];

	always_comb begin
		case (idx_q)
			CH_V:    x_sel = '0;
			CH_Q:    x_sel = f12;
			CH_T:    x_sel = 12'(HUE_SEG) - f12;
			CH_P:    x_sel = 12'(HUE_SEG);
			default: x_sel = '0;
		endcase
	end

	// one shared multiplier: s*x, then 17*v*(K - s*x)
	always_comb begin
		if (state_q == ST_MULB) begin
			mul_a = {val_now_q, 4'b0000} + {4'b0000, val_now_q};
			mul_b = K_SCALE - prod_q[23:0];
		end else begin
			mul_a = {4'b0000, sat_now_q};
			mul_b = {12'b0, x_sel};
		end
	end

	assign mul_p = 41'(mul_a) * 41'(mul_b);

	always_comb begin
		case (seg_q)
			3'd0:    begin r_sel = ch_q[CH_V]; g_sel = ch_q[CH_T]; b_sel = ch_q[CH_P]; end
			3'd1:    begin r_sel = ch_q[CH_Q]; g_sel = ch_q[CH_V]; b_sel = ch_q[CH_P]; end
			3'd2:    begin r_sel = ch_q[CH_P]; g_sel = ch_q[CH_V]; b_sel = ch_q[CH_T]; end
			3'd3:    begin r_sel = ch_q[CH_P]; g_sel = ch_q[CH_Q]; b_sel = ch_q[CH_V]; end
			3'd4:    begin r_sel = ch_q[CH_T]; g_sel = ch_q[CH_P]; b_sel = ch_q[CH_V]; end
			default: begin r_sel = ch_q[CH_V]; g_sel = ch_q[CH_P]; b_sel = ch_q[CH_Q]; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hue_now_q   <= '0;
			sat_now_q   <= '0;
			val_now_q   <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			seg_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (apply_mask[1]) begin
							sat_now_q <= clamp_unit(sat_next_raw);
						end
						if (apply_mask[2]) begin
							val_now_q <= clamp_unit(val_next_raw);
						end
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if (hw_q < 17'sd0) begin
						state_q <= ST_WRAP;
					end else if (hw_q >= 17'sd23040) begin
						state_q <= ST_WRAP;
					end else begin
						hue_now_q <= hw_q[HUE_W-1:0];
						seg_q     <= '0;
						state_q   <= ST_DIVSEG;
					end
				end
				ST_DIVSEG: begin
					if (f_q >= HUE_W'(HUE_SEG)) begin
						seg_q <= seg_q + 3'd1;
					end else begin
						idx_q   <= '0;
						state_q <= ST_MULA;
					end
				end
				ST_MULA: begin
					state_q <= ST_MULB;
				end
				ST_MULB: begin
					state_q <= ST_STORE;
				end
				ST_STORE: begin
					if (idx_q == CH_P) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_MULA;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			if (apply_mask[0]) begin
				hw_q <= hue_next_raw;
			end else begin
				hw_q <= $signed({2'b00, hue_now_q});
			end
		end else if (state_q == ST_WRAP) begin
			if (hw_q < 17'sd0) begin
				hw_q <= hw_q + 17'sd23040;
			end else if (hw_q >= 17'sd23040) begin
				hw_q <= hw_q - 17'sd23040;
			end
		end
		if (state_q == ST_WRAP) begin
			f_q <= hw_q[HUE_W-1:0];
		end else if (state_q == ST_DIVSEG && f_q >= HUE_W'(HUE_SEG)) begin
			f_q <= f_q - HUE_W'(HUE_SEG);
		end
		if (state_q == ST_MULA || state_q == ST_MULB) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_STORE) begin
			ch_q[idx_q] <= prod_q[39:32];
		end
		if (load_out) begin
			red_q   <= r_sel;
			green_q <= g_sel;
			blue_q  <= b_sel;
		end
	end

`ifndef NO_ASSERTIONS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hue_now_q < HUE_W'(HUE_FULL))
		else $error("hue state out of range");

	a_unit_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		sat_now_q <= SAT_W'(Q_ONE) && val_now_q <= SAT_W'(Q_ONE))
		else $error("saturation or value beyond one");

	a_seg_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULA) |-> (f_q < HUE_W'(HUE_SEG) && seg_q <= 3'd5))
		else $error("segment search left a bad remainder");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside of done state");
`endif

endmodule

`default_nettype wire
